// ----- rtl/core/ibalu_pkg.sv -----
// Shared types, constants and helper functions of the interval bound ALU.
// Used by every module under rtl/core; depends on nothing else.
package ibalu_pkg;

  typedef logic signed [63:0] s64_t;

  // Extremes that stand for plus and minus infinity
  localparam s64_t        POS_INF  = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam s64_t        NEG_INF  = 64'sh8000_0000_0000_0001;
  localparam logic [63:0] MIN_CODE = 64'h8000_0000_0000_0000;

  // Magnitude width of any bound and number of divider steps
  localparam int MAG_W     = 63;
  localparam int DIV_STEPS = MAG_W;
  localparam int SHIFT_MAX = 63;

  // Pipeline latencies, in registers after the input stage
  localparam int DIV_LAT  = DIV_STEPS + 2;
  localparam int MUL_LAT  = 5;
  localparam int SIMP_LAT = 2;

  // Type kinds
  localparam logic [1:0] KIND_SINT = 2'd0;
  localparam logic [1:0] KIND_UINT = 2'd1;

  typedef enum logic [3:0] {
    ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_MOD, ACT_FDIV, ACT_FMOD,
    ACT_MIN, ACT_MAX, ACT_UNION, ACT_ISECT, ACT_CAST, ACT_SHR, ACT_AND, ACT_BIND
  } act_t;

  typedef enum logic [1:0] {
    ST_OK, ST_ZERO_DIV, ST_OPP_INF
  } st_t;

  typedef struct packed {
    logic opp;
    s64_t val;
  } sat_t;

  typedef struct packed {
    s64_t lo;
    s64_t hi;
  } ivl_t;

  // Decoded operands of one transaction
  typedef struct packed {
    act_t       act;
    s64_t       alo;
    s64_t       ahi;
    s64_t       blo;
    s64_t       bhi;
    logic [1:0] kind;
    logic [6:0] bits;
  } op_t;

  // Results of the short path, carried alongside the divider
  typedef struct packed {
    act_t             act;
    s64_t             rlo;
    s64_t             rhi;
    st_t              st;
    logic [MAG_W-1:0] wmag;
    logic             bspan;
    s64_t [3:0]       cv;
  } side_t;

  function automatic s64_t load_s64(logic [63:0] v);
    return (v == MIN_CODE) ? NEG_INF : s64_t'(v);
  endfunction

  function automatic s64_t smin(s64_t x, s64_t y);
    return (x < y) ? x : y;
  endfunction

  function automatic s64_t smax(s64_t x, s64_t y);
    return (x > y) ? x : y;
  endfunction

  // Saturating add; opp flags a sum of opposite infinities
  function automatic sat_t sat_add(s64_t x, s64_t y);
    sat_t        r;
    logic [64:0] s;
    s     = {x[63], x} + {y[63], y};
    r.opp = 1'b0;
    if (x == POS_INF) begin
      r.val = POS_INF;
      r.opp = (y == NEG_INF);
    end else if (x == NEG_INF) begin
      r.val = NEG_INF;
      r.opp = (y == POS_INF);
    end else if (y == POS_INF || y == NEG_INF) begin
      r.val = y;
    end else if (s[64:63] == 2'b01) begin
      r.val = POS_INF;
    end else if (s[64] && (!s[63] || s[62:0] == '0)) begin
      r.val = NEG_INF;
    end else begin
      r.val = s64_t'(s[63:0]);
    end
    return r;
  endfunction

  function automatic ivl_t type_range(logic [1:0] kind, logic [6:0] bits);
    ivl_t       r;
    logic [6:0] nb;
    logic [6:0] vb;
    r.lo = NEG_INF;
    r.hi = POS_INF;
    nb   = (bits == '0) ? 7'd1 : bits;
    vb   = nb - ((kind == KIND_SINT) ? 7'd1 : 7'd0);
    if (kind == KIND_SINT || kind == KIND_UINT) begin
      if (vb < 7'(SHIFT_MAX)) begin
        r.hi = s64_t'((64'd1 << vb[5:0]) - 64'd1);
        r.lo = (kind == KIND_UINT) ? '0 : -s64_t'(64'd1 << vb[5:0]);
      end else if (kind == KIND_UINT) begin
        r.lo = '0;
      end
    end
    return r;
  endfunction

  function automatic logic [5:0] clamp_shift(s64_t s);
    logic [5:0] r;
    if (s < 0)
      r = '0;
    else if (s > s64_t'(SHIFT_MAX))
      r = 6'(SHIFT_MAX);
    else
      r = s[5:0];
    return r;
  endfunction

  // Arithmetic right shift; infinities pass unchanged
  function automatic s64_t shr_a(s64_t x, s64_t s);
    return (x == POS_INF || x == NEG_INF) ? x : (x >>> clamp_shift(s));
  endfunction

endpackage

// ----- rtl/core/interval_bound_alu_top.sv -----
// Top level of the interval bound ALU: input stage, multiplier and divider
// lanes, short path, corner min/max tree and output register. Depends on ibalu_pkg.
//
//  channel  dir  fields (low bit first)
//  s_*      in   tdata: a_min, a_max, b_min, b_max, type_bits; tuser: action, type_kind
//  m_*      out  tdata: r_min, r_max; tuser: status
//
// One transaction enters per cycle while the pipeline advances; the 63-stage
// divider (one quotient bit a stage) sets the depth. The whole pipeline advances
// whenever the output register is empty or being taken; otherwise it holds and
// s_tready is low. rst synchronously clears all valid bits.
module interval_bound_alu_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [263:0] s_tdata,  // a_min, a_max, b_min, b_max, type_bits, zero pad
  input  logic [5:0]   s_tuser,  // action, type_kind
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,  // r_min, r_max
  output logic [1:0]   m_tuser   // status
);
  import ibalu_pkg::*;

  localparam int SEL_STG  = 1 + DIV_LAT;
  localparam int OUT_STG  = SEL_STG + 3;
  localparam int SIDE_OUT = 1 + SIMP_LAT;
  localparam int SIDE_N   = SEL_STG + 2 - SIDE_OUT;
  localparam int SIDE_SEL = SEL_STG - SIDE_OUT - 1;
  localparam int MUL_N    = SEL_STG - (1 + MUL_LAT);

  logic             en;
  logic [OUT_STG:1] vld;
  op_t              op1;
  op_t              op_next;
  s64_t             dx [4];
  s64_t             dy [4];
  s64_t             dq [4];
  s64_t             mq [4];
  s64_t [3:0]       mq_pk;
  s64_t [3:0]       mul_d [MUL_N];
  side_t            side3;
  side_t            side_d [SIDE_N];
  side_t            sel_side;
  side_t            fin_side;
  s64_t [3:0]       cset;
  s64_t             lo01;
  s64_t             lo23;
  s64_t             hi01;
  s64_t             hi23;
  s64_t             tlo;
  s64_t             thi;
  s64_t             r_min;
  s64_t             r_max;
  s64_t             r_min_next;
  s64_t             r_max_next;
  s64_t             wv;
  st_t              status;
  act_t             out_act;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[OUT_STG];
  assign m_tdata  = {r_max, r_min};
  assign m_tuser  = status;

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[OUT_STG-1:1], s_tvalid};
    end
  end

  // Decode the input transaction
  always_comb begin
    op_next.act  = act_t'(s_tuser[3:0]);
    op_next.kind = s_tuser[5:4];
    op_next.alo  = load_s64(s_tdata[63:0]);
    op_next.ahi  = load_s64(s_tdata[127:64]);
    op_next.blo  = load_s64(s_tdata[191:128]);
    op_next.bhi  = load_s64(s_tdata[255:192]);
    op_next.bits = s_tdata[262:256];
  end

  always_ff @(posedge clk) begin
    if (en)
      op1 <= op_next;
  end

  // Corner operands; a zero divisor bound becomes 1 or -1
  always_comb begin
    s64_t bl;
    s64_t bh;
    bl    = (op1.blo == 0) ? 64'sd1 : op1.blo;
    bh    = (op1.bhi == 0) ? -64'sd1 : op1.bhi;
    dx[0] = op1.alo;  dy[0] = bl;
    dx[1] = op1.ahi;  dy[1] = bh;
    dx[2] = op1.alo;  dy[2] = bh;
    dx[3] = op1.ahi;  dy[3] = bl;
  end

  for (genvar i = 0; i < 4; i++) begin : g_lane
    ibalu_div u_div (
      .clk (clk),
      .en  (en),
      .x   (dx[i]),
      .y   (dy[i]),
      .flr (op1.act == ACT_FDIV),
      .q   (dq[i])
    );

    // Lanes 0 and 3 take b_min, lanes 1 and 2 take b_max
    ibalu_mul u_mul (
      .clk (clk),
      .en  (en),
      .x   (dx[i]),
      .y   (((i == 0) || (i == 3)) ? op1.blo : op1.bhi),
      .p   (mq[i])
    );

    assign mq_pk[i] = mq[i];
  end

  ibalu_simple u_simple (
    .clk  (clk),
    .en   (en),
    .op   (op1),
    .side (side3)
  );

  // Align products and short-path results with the divider
  always_ff @(posedge clk) begin
    if (en) begin
      mul_d[0]  <= mq_pk;
      side_d[0] <= side3;
      for (int k = 1; k < MUL_N; k++)
        mul_d[k] <= mul_d[k-1];
      for (int k = 1; k < SIDE_N; k++)
        side_d[k] <= side_d[k-1];
    end
  end

  assign sel_side = side_d[SIDE_SEL];
  assign fin_side = side_d[SIDE_N-1];

  // Pick the four corners for the min/max tree
  always_comb begin
    if (sel_side.act == ACT_DIV || sel_side.act == ACT_FDIV) begin
      for (int i = 0; i < 4; i++)
        cset[i] = dq[i];
    end else if (sel_side.act == ACT_MUL) begin
      cset = mul_d[MUL_N-1];
    end else begin
      cset = sel_side.cv;
    end
  end

  // Two-level min/max tree
  always_ff @(posedge clk) begin
    if (en) begin
      lo01 <= smin(cset[0], cset[1]);
      lo23 <= smin(cset[2], cset[3]);
      hi01 <= smax(cset[0], cset[1]);
      hi23 <= smax(cset[2], cset[3]);
      tlo  <= smin(lo01, lo23);
      thi  <= smax(hi01, hi23);
    end
  end

  // Final select; widen the quotient when the divisor spans zero
  always_comb begin
    wv = s64_t'({1'b0, fin_side.wmag});
    case (fin_side.act)
      ACT_DIV, ACT_FDIV: begin
        r_min_next = fin_side.bspan ? smin(tlo, -wv) : tlo;
        r_max_next = fin_side.bspan ? smax(thi, wv) : thi;
      end
      ACT_MUL, ACT_SHR: begin
        r_min_next = tlo;
        r_max_next = thi;
      end
      default: begin
        r_min_next = fin_side.rlo;
        r_max_next = fin_side.rhi;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_min   <= r_min_next;
      r_max   <= r_max_next;
      status  <= fin_side.st;
      out_act <= fin_side.act;
    end
  end

  // Output is empty right after reset
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // Zero divisor status only from the divide and modulo family
  a_zdiv_src: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ST_ZERO_DIV) |->
      (out_act == ACT_DIV || out_act == ACT_FDIV ||
       out_act == ACT_MOD || out_act == ACT_FMOD))
    else $error("zero divisor status from a non-divide operation");

  // Opposite infinity status only from the adders
  a_opp_src: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ST_OPP_INF) |->
      (out_act == ACT_ADD || out_act == ACT_SUB || out_act == ACT_BIND))
    else $error("opposite infinity status from a non-add operation");

endmodule

// ----- rtl/core/ibalu_div.sv -----
// Pipelined signed divider, one quotient bit per stage, truncating or floor.
// Depends on ibalu_pkg.
module ibalu_div (
  input  logic              clk,
  input  logic              en,
  input  ibalu_pkg::s64_t   x,
  input  ibalu_pkg::s64_t   y,
  input  logic              flr,
  output ibalu_pkg::s64_t   q
);
  import ibalu_pkg::*;

  typedef struct packed {
    logic [MAG_W-1:0] rem;
    logic [MAG_W-1:0] num;
    logic [MAG_W-1:0] d;
    logic             neg;
    logic             flr;
    logic             xinf;
  } dstep_t;

  dstep_t stg [DIV_STEPS+1];
  dstep_t stg_next [DIV_STEPS+1];
  s64_t   q_next;
  s64_t   ax;
  s64_t   ay;

  // Take magnitudes and sign of the quotient, then one restoring step per stage
  always_comb begin
    logic [MAG_W:0] t;
    logic           ge;
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    stg_next[0].rem  = '0;
    stg_next[0].num  = ax[MAG_W-1:0];
    stg_next[0].d    = ay[MAG_W-1:0];
    stg_next[0].neg  = (x < 0) != (y < 0);
    stg_next[0].flr  = flr;
    stg_next[0].xinf = (x == POS_INF) || (x == NEG_INF);
    for (int k = 0; k < DIV_STEPS; k++) begin
      t  = {stg[k].rem, stg[k].num[MAG_W-1]};
      ge = (t >= {1'b0, stg[k].d});
      stg_next[k+1]      = stg[k];
      stg_next[k+1].rem  = ge ? MAG_W'(t - {1'b0, stg[k].d}) : t[MAG_W-1:0];
      stg_next[k+1].num  = {stg[k].num[MAG_W-2:0], ge};
    end
  end

  // Apply sign, floor correction and infinite dividend
  always_comb begin
    s64_t qm;
    qm = s64_t'({1'b0, stg[DIV_STEPS].num});
    if (stg[DIV_STEPS].xinf)
      q_next = stg[DIV_STEPS].neg ? NEG_INF : POS_INF;
    else if (stg[DIV_STEPS].neg)
      q_next = (stg[DIV_STEPS].flr && stg[DIV_STEPS].rem != '0) ? ~qm : -qm;
    else
      q_next = qm;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= DIV_STEPS; k++)
        stg[k] <= stg_next[k];
      q <= q_next;
    end
  end

endmodule

// ----- rtl/core/ibalu_mul.sv -----
// Pipelined saturating signed multiplier built from 32- and 31-bit partial products.
// Depends on ibalu_pkg.
module ibalu_mul (
  input  logic            clk,
  input  logic            en,
  input  ibalu_pkg::s64_t x,
  input  ibalu_pkg::s64_t y,
  output ibalu_pkg::s64_t p
);
  import ibalu_pkg::*;

  logic [MAG_W-1:0] mx;
  logic [MAG_W-1:0] my;
  logic [4:1]       neg;
  logic [63:0]      ll;
  logic [62:0]      lh;
  logic [62:0]      hl;
  logic [61:0]      hh;
  logic [63:0]      ll2;
  logic [63:0]      mid;
  logic             hhnz;
  logic             hhnz3;
  logic [96:0]      t;
  s64_t             ax;
  s64_t             ay;
  s64_t             tv;

  always_comb begin
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    tv = s64_t'({1'b0, t[MAG_W-1:0]});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Magnitudes and product sign
      mx     <= ax[MAG_W-1:0];
      my     <= ay[MAG_W-1:0];
      neg[1] <= (x < 0) != (y < 0);
      // Partial products
      ll     <= mx[31:0] * my[31:0];
      lh     <= mx[31:0] * my[62:32];
      hl     <= mx[62:32] * my[31:0];
      hh     <= mx[62:32] * my[62:32];
      neg[2] <= neg[1];
      // Fold the middle terms
      mid    <= {1'b0, lh} + {1'b0, hl};
      ll2    <= ll;
      hhnz   <= (hh != '0);
      neg[3] <= neg[2];
      // Sum of the low and middle partial products, 97 bits wide
      t      <= {33'b0, ll2} + {1'b0, mid, 32'b0};
      hhnz3  <= hhnz;
      neg[4] <= neg[3];
      // Saturate and apply sign
      if (hhnz3 || t[96:MAG_W] != '0)
        p <= neg[4] ? NEG_INF : POS_INF;
      else
        p <= neg[4] ? -tv : tv;
    end
  end

endmodule

// ----- rtl/core/ibalu_simple.sv -----
// Short path: saturating add and sub, bounds of mod, min, max, union, intersect,
// cast, and and bind, plus shift corners and divide widening. Depends on ibalu_pkg.
module ibalu_simple (
  input  logic               clk,
  input  logic               en,
  input  ibalu_pkg::op_t     op,
  output ibalu_pkg::side_t   side
);
  import ibalu_pkg::*;

  op_t              o2;
  sat_t             sum_lo;
  sat_t             sum_hi;
  sat_t             ext_sum;
  s64_t             ext;
  ivl_t             tr;
  s64_t [3:0]       cv;
  logic [MAG_W-1:0] abs_lo;
  logic [MAG_W-1:0] abs_hi;
  logic             bzero;
  logic             bspan;
  side_t            side_next;

  assign ext_sum = sat_add(op.bhi, -64'sd1);

  // First stage: sums, type range, shifts, magnitudes
  always_ff @(posedge clk) begin
    if (en) begin
      o2     <= op;
      sum_lo <= sat_add(op.alo, (op.act == ACT_SUB) ? -op.bhi : op.blo);
      sum_hi <= sat_add(op.ahi, (op.act == ACT_SUB) ? -op.blo : op.bhi);
      ext    <= ext_sum.val;
      tr     <= type_range(op.kind, op.bits);
      cv[0]  <= shr_a(op.alo, op.blo);
      cv[1]  <= shr_a(op.ahi, op.bhi);
      cv[2]  <= shr_a(op.alo, op.bhi);
      cv[3]  <= shr_a(op.ahi, op.blo);
      abs_lo <= (op.alo < 0) ? MAG_W'(-op.alo) : op.alo[MAG_W-1:0];
      abs_hi <= (op.ahi < 0) ? MAG_W'(-op.ahi) : op.ahi[MAG_W-1:0];
      bzero  <= (op.blo == 0) && (op.bhi == 0);
      bspan  <= (op.blo < 0) && (op.bhi > 0);
    end
  end

  // Second stage: pick the interval for the operation
  always_comb begin
    sat_t bs;
    bs              = sat_add(o2.ahi, ext);
    side_next.act   = o2.act;
    side_next.rlo   = NEG_INF;
    side_next.rhi   = POS_INF;
    side_next.st    = ST_OK;
    side_next.wmag  = (abs_lo > abs_hi) ? abs_lo : abs_hi;
    side_next.bspan = bspan;
    side_next.cv    = cv;
    unique case (o2.act)
      ACT_ADD, ACT_SUB: begin
        side_next.rlo = sum_lo.val;
        side_next.rhi = sum_hi.val;
        side_next.st  = (sum_lo.opp || sum_hi.opp) ? ST_OPP_INF : ST_OK;
      end
      ACT_DIV, ACT_FDIV: begin
        side_next.st = bzero ? ST_ZERO_DIV : ST_OK;
      end
      ACT_MOD, ACT_FMOD: begin
        if (o2.blo > 0) begin
          if (o2.alo >= 0) begin
            if (o2.ahi < o2.blo) begin
              side_next.rlo = o2.alo;
              side_next.rhi = o2.ahi;
            end else begin
              side_next.rlo = '0;
              side_next.rhi = smin(o2.ahi, ext);
            end
          end else if (o2.act == ACT_MOD) begin
            side_next.rlo = smax(o2.alo, -ext);
            side_next.rhi = smin(smax(o2.ahi, '0), ext);
          end else begin
            side_next.rlo = '0;
            side_next.rhi = ext;
          end
        end else begin
          side_next.st  = bzero ? ST_ZERO_DIV : ST_OK;
          side_next.rlo = tr.lo;
          side_next.rhi = tr.hi;
        end
      end
      ACT_MIN: begin
        side_next.rlo = smin(o2.alo, o2.blo);
        side_next.rhi = smin(o2.ahi, o2.bhi);
      end
      ACT_MAX: begin
        side_next.rlo = smax(o2.alo, o2.blo);
        side_next.rhi = smax(o2.ahi, o2.bhi);
      end
      ACT_UNION: begin
        side_next.rlo = smin(o2.alo, o2.blo);
        side_next.rhi = smax(o2.ahi, o2.bhi);
      end
      ACT_ISECT: begin
        side_next.rlo = smax(o2.alo, o2.blo);
        side_next.rhi = smin(o2.ahi, o2.bhi);
      end
      ACT_CAST: begin
        side_next.rlo = smax(o2.alo, tr.lo);
        side_next.rhi = smin(o2.ahi, tr.hi);
      end
      ACT_AND: begin
        side_next.rlo = '0;
        if (o2.alo >= 0 && o2.blo >= 0)
          side_next.rhi = smin(o2.ahi, o2.bhi);
        else if (o2.blo >= 0)
          side_next.rhi = o2.bhi;
        else if (o2.alo >= 0)
          side_next.rhi = o2.ahi;
        else begin
          side_next.rlo = tr.lo;
          side_next.rhi = tr.hi;
        end
      end
      ACT_BIND: begin
        side_next.rlo = o2.alo;
        side_next.rhi = bs.val;
        side_next.st  = bs.opp ? ST_OPP_INF : ST_OK;
      end
      default: begin
        side_next.st = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en)
      side <= side_next;
  end

endmodule

// ----- sim/interval_bound_alu_checker.sv -----
// Checker for the interval bound ALU: watches both stream channels, predicts each result
// interval from the accepted operands and compares it. Depends on ibalu_pkg.
module interval_bound_alu_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [263:0] s_tdata,
  input  logic [5:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [127:0] m_tdata,
  input  logic [1:0]   m_tuser,
  output int           errors,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import ibalu_pkg::*;

  typedef struct {
    s64_t lo;
    s64_t hi;
    st_t  st;
  } bound_t;

  bound_t intervals_due[$];

  function automatic s64_t decode_bound(logic [63:0] v);
    return (v == MIN_CODE) ? NEG_INF : s64_t'(v);
  endfunction

  function automatic s64_t lesser(s64_t x, s64_t y);
    return (x < y) ? x : y;
  endfunction

  function automatic s64_t greater(s64_t x, s64_t y);
    return (x > y) ? x : y;
  endfunction

  // Saturating sum; opposite infinities keep the first operand and flag status
  function automatic s64_t clip_sum(s64_t x, s64_t y, inout st_t st);
    if (x == POS_INF) begin
      if (y == NEG_INF) st = ST_OPP_INF;
      return POS_INF;
    end
    if (x == NEG_INF) begin
      if (y == POS_INF) st = ST_OPP_INF;
      return NEG_INF;
    end
    if (y == POS_INF || y == NEG_INF) return y;
    if (y > 0 && x > POS_INF - y) return POS_INF;
    if (y < 0 && x < NEG_INF - y) return NEG_INF;
    return x + y;
  endfunction

  function automatic s64_t clip_product(s64_t x, s64_t y);
    logic [63:0] mx, my, p;
    logic        neg;
    mx  = (x < 0) ? 64'(-x) : 64'(x);
    my  = (y < 0) ? 64'(-y) : 64'(y);
    neg = (x < 0) != (y < 0);
    if (mx == 0 || my == 0) return 0;
    if (mx > 64'h7FFF_FFFF_FFFF_FFFF / my) return neg ? NEG_INF : POS_INF;
    p = mx * my;
    return neg ? -s64_t'(p) : s64_t'(p);
  endfunction

  // Quotient with truncation or floor; infinities keep their magnitude
  function automatic s64_t quotient(s64_t x, s64_t y, logic flr);
    s64_t q, rem;
    if (x == POS_INF || x == NEG_INF) return (y > 0) ? x : -x;
    q   = x / y;
    rem = x % y;
    if (flr && rem != 0 && ((x < 0) != (y < 0))) q = q - 1;
    return q;
  endfunction

  function automatic s64_t shift_bound(s64_t x, s64_t s);
    int amt;
    if (x == POS_INF || x == NEG_INF) return x;
    amt = (s < 0) ? 0 : (s > 63) ? 63 : int'(s);
    return x >>> amt;
  endfunction

  function automatic bound_t span(s64_t v0, s64_t v1, s64_t v2, s64_t v3);
    bound_t r;
    r.lo = lesser(lesser(v0, v1), lesser(v2, v3));
    r.hi = greater(greater(v0, v1), greater(v2, v3));
    r.st = ST_OK;
    return r;
  endfunction

  function automatic bound_t kind_limits(logic [1:0] kind, logic [6:0] bits);
    bound_t r;
    int     vb;
    r.lo = NEG_INF;
    r.hi = POS_INF;
    r.st = ST_OK;
    if (kind > 1) return r;
    vb = ((bits == 0) ? 1 : int'(bits)) - ((kind == KIND_SINT) ? 1 : 0);
    if (vb < 63) begin
      r.hi = s64_t'((64'd1 << vb) - 64'd1);
      r.lo = (kind == KIND_UINT) ? 0 : -s64_t'(64'd1 << vb);
    end else if (kind == KIND_UINT) begin
      r.lo = 0;
    end
    return r;
  endfunction

  function automatic bound_t divide_span(s64_t alo, s64_t ahi, s64_t blo, s64_t bhi,
                                         logic flr);
    bound_t r, w;
    if (blo == 0) blo = 1;
    if (bhi == 0) bhi = -1;
    r = span(quotient(alo, blo, flr), quotient(ahi, bhi, flr),
             quotient(alo, bhi, flr), quotient(ahi, blo, flr));
    // Divisor spanning zero: widen with division by one and minus one
    if (blo < 0 && bhi > 0) begin
      w = span(quotient(alo, 1, flr), quotient(ahi, 1, flr),
               quotient(alo, -1, flr), quotient(ahi, -1, flr));
      r.lo = lesser(r.lo, w.lo);
      r.hi = greater(r.hi, w.hi);
    end
    return r;
  endfunction

  function automatic bound_t predict_interval(logic [263:0] d, logic [5:0] u);
    bound_t     r, t;
    st_t        st;
    s64_t       alo, ahi, blo, bhi, cap;
    logic [3:0] act;
    logic [1:0] kind;
    logic [6:0] bits;
    logic       bzero;
    alo   = decode_bound(d[63:0]);
    ahi   = decode_bound(d[127:64]);
    blo   = decode_bound(d[191:128]);
    bhi   = decode_bound(d[255:192]);
    bits  = d[262:256];
    act   = u[3:0];
    kind  = u[5:4];
    st    = ST_OK;
    bzero = (blo == 0 && bhi == 0);
    r.lo  = NEG_INF;
    r.hi  = POS_INF;
    case (act)
      ACT_ADD: begin
        r.lo = clip_sum(alo, blo, st);
        r.hi = clip_sum(ahi, bhi, st);
      end
      ACT_SUB: begin
        r.lo = clip_sum(alo, -bhi, st);
        r.hi = clip_sum(ahi, -blo, st);
      end
      ACT_MUL: r = span(clip_product(alo, blo), clip_product(ahi, bhi),
                        clip_product(alo, bhi), clip_product(ahi, blo));
      ACT_DIV, ACT_FDIV: begin
        if (bzero) st = ST_ZERO_DIV;
        r = divide_span(alo, ahi, blo, bhi, act == ACT_FDIV);
      end
      ACT_MOD, ACT_FMOD: begin
        if (blo > 0) begin
          cap = clip_sum(bhi, -1, st);
          if (alo >= 0) begin
            if (ahi < blo) begin
              r.lo = alo;
              r.hi = ahi;
            end else begin
              r.lo = 0;
              r.hi = lesser(ahi, cap);
            end
          end else if (act == ACT_MOD) begin
            r.lo = greater(alo, -cap);
            r.hi = lesser(greater(ahi, 0), cap);
          end else begin
            r.lo = 0;
            r.hi = cap;
          end
        end else begin
          if (bzero) st = ST_ZERO_DIV;
          r = kind_limits(kind, bits);
        end
      end
      ACT_MIN: begin
        r.lo = lesser(alo, blo);
        r.hi = lesser(ahi, bhi);
      end
      ACT_MAX: begin
        r.lo = greater(alo, blo);
        r.hi = greater(ahi, bhi);
      end
      ACT_UNION: begin
        r.lo = lesser(alo, blo);
        r.hi = greater(ahi, bhi);
      end
      ACT_ISECT: begin
        r.lo = greater(alo, blo);
        r.hi = lesser(ahi, bhi);
      end
      ACT_CAST: begin
        t    = kind_limits(kind, bits);
        r.lo = greater(alo, t.lo);
        r.hi = lesser(ahi, t.hi);
      end
      ACT_SHR: r = span(shift_bound(alo, blo), shift_bound(ahi, bhi),
                        shift_bound(alo, bhi), shift_bound(ahi, blo));
      ACT_AND: begin
        r.lo = 0;
        if (alo >= 0 && blo >= 0) r.hi = lesser(ahi, bhi);
        else if (blo >= 0) r.hi = bhi;
        else if (alo >= 0) r.hi = ahi;
        else r = kind_limits(kind, bits);
      end
      ACT_BIND: begin
        cap  = clip_sum(bhi, -1, st);
        r.lo = alo;
        r.hi = clip_sum(ahi, cap, st);
      end
      default: ;
    endcase
    r.st = st;
    return r;
  endfunction

  assign pending = intervals_due.size();

  // Queue a prediction per input transaction, check each output transaction
  always @(posedge clk) begin
    bound_t want;
    if (rst) begin
      intervals_due.delete();
      errors <= 0;
    end else begin
      if (s_tvalid && s_tready) intervals_due.push_back(predict_interval(s_tdata, s_tuser));
      if (m_tvalid && m_tready) begin
        if (intervals_due.size() == 0) begin
          $display("%0t: result with none due: %h %h %0d", $realtime,
                   m_tdata[63:0], m_tdata[127:64], m_tuser);
          errors <= errors + 1;
        end else begin
          want = intervals_due.pop_front();
          if (m_tdata[63:0] !== want.lo || m_tdata[127:64] !== want.hi ||
              m_tuser !== want.st) begin
            $display("%0t: expected [%0d,%0d] st %0d, got [%0d,%0d] st %0d", $realtime,
                     want.lo, want.hi, want.st, $signed(m_tdata[63:0]),
                     $signed(m_tdata[127:64]), m_tuser);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

// ----- sim/tb.sv -----
// Testbench top of the interval bound ALU: clock, reset, stream stimulus and verdict.
// Depends on ibalu_pkg, interval_bound_alu_top and interval_bound_alu_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ibalu_pkg::*;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [263:0] s_tdata = '0;
  logic [5:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;
  logic [1:0]   m_tuser;
  int           errors;
  int           pending;
  int           send_pct = 0;
  int           stall_pct = 0;
  bit           hold_req = 1'b0;

  interval_bound_alu_top uut (.*);

  interval_bound_alu_checker chk (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // Hang guard
  initial begin
    #2_000_000;
    $display("tb: errors");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !rst && ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offer one transaction and wait until it is taken, then maybe idle
  task automatic offer(logic [3:0] act, logic [63:0] alo, logic [63:0] ahi,
                       logic [63:0] blo, logic [63:0] bhi, logic [1:0] kind,
                       logic [6:0] bits);
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, bits, bhi, blo, ahi, alo};
    s_tuser  <= {kind, act};
    do @(posedge clk); while (!s_tready);
    if ($urandom_range(99) < send_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  function automatic logic [63:0] pick_bound();
    case ($urandom_range(9))
      0:       return POS_INF;
      1:       return NEG_INF;
      2:       return MIN_CODE;
      3:       return 64'd0;
      4, 5:    return {$urandom, $urandom};
      6:       return 64'(65'sd1 <<< $urandom_range(62)) - 64'($urandom_range(2));
      default: return 64'($signed($urandom_range(80)) - 40);
    endcase
  endfunction

  task automatic random_item();
    logic [63:0] p, q, r, s, t;
    logic [6:0]  bits;
    p = pick_bound();
    q = pick_bound();
    r = pick_bound();
    s = pick_bound();
    // Mostly ordered intervals; the rest stay as drawn
    if ($urandom_range(9) < 8) begin
      if ($signed(p) > $signed(q)) begin t = p; p = q; q = t; end
      if ($signed(r) > $signed(s)) begin t = r; r = s; s = t; end
    end
    bits = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(64, 1));
    offer(4'($urandom_range(15)), p, q, r, s, 2'($urandom_range(3)), bits);
  endtask

  initial begin
    int wait_cycles;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, every operation and the named corner cases
    offer(ACT_ADD,   POS_INF, POS_INF, NEG_INF, 64'd5, KIND_SINT, 7'd32);
    offer(ACT_ADD,   NEG_INF, 64'd3, POS_INF, POS_INF, KIND_SINT, 7'd32);
    offer(ACT_SUB,   MIN_CODE, 64'd10, 64'd2, POS_INF, KIND_SINT, 7'd8);
    offer(ACT_MUL,   NEG_INF, POS_INF, 64'd0, 64'd0, KIND_SINT, 7'd8);
    offer(ACT_MUL,   64'h4000_0000_0000_0000, POS_INF, -64'd3, 64'd2, KIND_UINT, 7'd8);
    offer(ACT_DIV,   -64'd7, 64'd9, 64'd0, 64'd0, KIND_SINT, 7'd16);
    offer(ACT_DIV,   NEG_INF, 64'd100, -64'd4, 64'd3, KIND_SINT, 7'd16);
    offer(ACT_FDIV,  -64'd7, 64'd9, 64'd2, 64'd3, KIND_SINT, 7'd16);
    offer(ACT_FDIV,  -64'd7, POS_INF, -64'd3, 64'd0, KIND_SINT, 7'd16);
    offer(ACT_MOD,   -64'd20, 64'd9, 64'd4, 64'd6, KIND_SINT, 7'd16);
    offer(ACT_MOD,   64'd1, 64'd3, 64'd5, 64'd9, KIND_SINT, 7'd16);
    offer(ACT_MOD,   64'd1, 64'd3, 64'd0, 64'd0, KIND_UINT, 7'd0);
    offer(ACT_FMOD,  -64'd20, 64'd9, 64'd4, 64'd6, KIND_SINT, 7'd16);
    offer(ACT_FMOD,  64'd1, 64'd3, -64'd2, 64'd6, KIND_SINT, 7'd64);
    offer(ACT_MIN,   NEG_INF, 64'd4, 64'd2, POS_INF, KIND_SINT, 7'd1);
    offer(ACT_MAX,   NEG_INF, 64'd4, 64'd2, POS_INF, KIND_SINT, 7'd1);
    offer(ACT_UNION, -64'd1, 64'd4, 64'd2, 64'd9, KIND_SINT, 7'd1);
    offer(ACT_ISECT, 64'd10, 64'd20, 64'd30, 64'd40, KIND_SINT, 7'd1);
    offer(ACT_CAST,  NEG_INF, POS_INF, 64'd0, 64'd0, KIND_SINT, 7'd64);
    offer(ACT_CAST,  -64'd5, 64'd500, 64'd0, 64'd0, KIND_UINT, 7'd8);
    offer(ACT_CAST,  -64'd5, 64'd500, 64'd0, 64'd0, 2'd2, 7'd8);
    offer(ACT_SHR,   -64'd1000, POS_INF, -64'd5, 64'd200, KIND_SINT, 7'd32);
    offer(ACT_AND,   -64'd3, 64'd7, -64'd2, 64'd9, KIND_SINT, 7'd127);
    offer(ACT_BIND,  64'd4, POS_INF, NEG_INF, NEG_INF, KIND_SINT, 7'd32);
    offer(4'd15,     64'd1, 64'd2, 64'd3, 64'd4, KIND_SINT, 7'd32);

    // Random phases: free with one long receiver hold-off, sender idle, receiver stalling, both
    for (int ph = 0; ph < 4; ph++) begin
      send_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 26 : 61) : 0;
      stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 26 : 61) : 0;
      if (ph == 0) hold_req = 1'b1;
      repeat (150) random_item();
    end
    s_tvalid <= 1'b0;

    // Drain
    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (80) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/core/ibalu_pkg.sv
rtl/core/ibalu_div.sv
rtl/core/ibalu_mul.sv
rtl/core/ibalu_simple.sv
rtl/core/interval_bound_alu_top.sv
sim/interval_bound_alu_checker.sv
sim/tb.sv
